FILE: sv/vgrm_pkg.sv
package vgrm_pkg;

    // Map geometry defaults and store size.
    localparam int MAP_WIDTH_DEF  = 32;
    localparam int MAP_DEPTH_DEF  = 32;
    localparam int MAP_HEIGHT_DEF = 8;
    localparam int STORE_CELLS    = 8192;
    localparam int STORE_AW       = 13;

    // Fixed-point widths.
    localparam int POS_W  = 24;
    localparam int DIR_W  = 18;
    localparam int DIST_W = 32;
    localparam int GRID_W = 10;
    localparam int QUO_W  = 33;
    localparam int DEN_W  = 18;

    // Op codes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Cell codes.
    localparam logic [1:0] CELL_EMPTY   = 2'd0;
    localparam logic [1:0] CELL_SOLID   = 2'd1;
    localparam logic [1:0] CELL_OUTSIDE = 2'd2;

    // Normal axis codes.
    localparam logic [1:0] AXIS_NONE = 2'd0;

    localparam logic [3:0] MAX_STEPS_RST = 4'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                wr_voxel;
        logic                clr_wr;
        logic [STORE_AW-1:0] clr_addr;
        logic [1:0]          axis;
        logic                div_start;
        logic                div_cap;
        logic                pick;
        logic                mul;
        logic                acc;
        logic                rd;
        logic                check;
        logic                publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic cell_stop;
    } t_status;

endpackage

FILE: sv/vgrm_ram.sv
module vgrm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/vgrm_div.sv
module vgrm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [vgrm_pkg::QUO_W-1:0] i_num,
    input  logic [vgrm_pkg::DEN_W-1:0] i_den,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [vgrm_pkg::QUO_W-1:0] o_quo
);
    import vgrm_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [QUO_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   trial;

    // One quotient bit per cycle, restoring.
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = DEN_W'(trial - {1'b0, r_den});
            n_quo = {r_quo[QUO_W-2:0], 1'b1};
        end else begin
            n_rem = trial[DEN_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sv/vgrm_datapath.sv
module vgrm_datapath #(
    parameter int MAP_WIDTH  = vgrm_pkg::MAP_WIDTH_DEF,
    parameter int MAP_DEPTH  = vgrm_pkg::MAP_DEPTH_DEF,
    parameter int MAP_HEIGHT = vgrm_pkg::MAP_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vgrm_pkg::t_cmd                    i_cmd,
    output vgrm_pkg::t_status                 o_status,
    input  logic [12:0]                       i_voxel_index,
    input  logic [7:0]                        i_voxel_byte,
    input  logic signed [vgrm_pkg::POS_W-1:0] i_start_x,
    input  logic signed [vgrm_pkg::POS_W-1:0] i_start_y,
    input  logic signed [vgrm_pkg::POS_W-1:0] i_start_z,
    input  logic signed [vgrm_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [vgrm_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [vgrm_pkg::DIR_W-1:0] i_dir_z,
    output logic signed [vgrm_pkg::POS_W-1:0] o_hit_x,
    output logic signed [vgrm_pkg::POS_W-1:0] o_hit_y,
    output logic signed [vgrm_pkg::POS_W-1:0] o_hit_z,
    output logic [1:0]                        o_normal_axis,
    output logic                              o_normal_negative,
    output logic [1:0]                        o_cell_code
);
    import vgrm_pkg::*;

    localparam logic signed [DIST_W-1:0] DIST_INF = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_NEG = {1'b1, {(DIST_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [8:0]               W9       = 9'(MAP_WIDTH);
    localparam logic [16:0]              WD17     = 17'(MAP_WIDTH * MAP_DEPTH);

    logic signed [POS_W-1:0]  r_pos  [3];
    logic signed [DIR_W-1:0]  r_dir  [3];
    logic signed [GRID_W-1:0] r_grid [3];
    logic signed [DIST_W-1:0] r_dist [3];
    logic signed [DIST_W-1:0] r_d;
    logic [1:0]               r_axis;
    logic [1:0]               r_code;
    logic                     r_nneg, r_dzero;
    logic signed [49:0]       r_prod;
    logic                     r_outside, r_past;

    logic signed [POS_W-1:0] r_hit_x, r_hit_y, r_hit_z;
    logic [1:0]              r_out_axis, r_out_code;
    logic                    r_out_neg;

    // Start cell: coordinates truncated toward zero.
    function automatic logic signed [GRID_W-1:0] start_cell(input logic signed [POS_W-1:0] p);
        logic signed [POS_W:0] t;
        t = p[POS_W-1] ? ($signed({p[POS_W-1], p}) + (POS_W+1)'(65535)) : {p[POS_W-1], p};
        return GRID_W'(t >>> 16);
    endfunction

    // Numerator for the distance of the current axis.
    logic signed [POS_W-1:0] cur_pos;
    logic signed [DIR_W-1:0] cur_dir;
    logic                    crossed;
    logic signed [17:0]      frac;
    logic signed [18:0]      num;
    logic [16:0]             num_mag;
    logic [DEN_W-1:0]        den;

    assign cur_pos = r_pos[i_cmd.axis];
    assign cur_dir = r_dir[i_cmd.axis];
    assign crossed = (r_axis == (i_cmd.axis + 2'd1));

    always_comb begin
        if (cur_pos[POS_W-1] && (cur_pos[15:0] != 16'd0)) begin
            frac = $signed({2'b00, cur_pos[15:0]}) - 18'sd65536;
        end else if (cur_pos[POS_W-1]) begin
            frac = '0;
        end else begin
            frac = $signed({2'b00, cur_pos[15:0]});
        end
        if (crossed) begin
            num = 19'sd65536;
        end else if (cur_dir > 0) begin
            num = 19'sd65536 - 19'(frac);
        end else begin
            num = 19'(frac);
        end
        num_mag = num[18] ? 17'(-num) : 17'(num);
        den     = cur_dir[DIR_W-1] ? DEN_W'(-cur_dir) : DEN_W'(cur_dir);
    end

    logic [QUO_W-1:0] quo;

    vgrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({num_mag, 16'd0}),
        .i_den   (den),
        .o_busy  (o_status.div_busy),
        .o_done  (o_status.div_done),
        .o_quo   (quo)
    );

    // Signed, saturated distance from the quotient magnitude.
    logic signed [DIST_W-1:0] dist_val;
    always_comb begin
        if (r_dzero) begin
            dist_val = DIST_INF;
        end else if (r_nneg) begin
            dist_val = (quo > QUO_W'(33'h80000000)) ? DIST_NEG : DIST_W'(-quo);
        end else begin
            dist_val = (quo > QUO_W'(33'h7FFFFFFF)) ? DIST_INF : DIST_W'(quo);
        end
    end

    // Axis pick: strict minimum on x or y, else z.
    logic [1:0] pick;
    always_comb begin
        if (r_dist[0] < r_dist[1] && r_dist[0] < r_dist[2]) begin
            pick = 2'd0;
        end else if (r_dist[1] < r_dist[0] && r_dist[1] < r_dist[2]) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
    end

    // Position update, product truncated toward zero.
    logic signed [33:0] delta;
    logic signed [34:0] sum;
    always_comb begin
        delta = 34'((r_prod + (r_prod[49] ? 50'sd65535 : 50'sd0)) >>> 16);
        sum   = 35'(r_pos[i_cmd.axis]) + 35'(delta);
    end

    // Bounds test and linear index of the current cell.
    logic        outside;
    logic [25:0] idx;
    always_comb begin
        outside = (r_grid[0] < 0) || (r_grid[0] >= $signed(11'(MAP_WIDTH))) ||
                  (r_grid[1] < 0) || (r_grid[1] >= $signed(11'(MAP_DEPTH))) ||
                  (r_grid[2] < 0) || (r_grid[2] >= $signed(11'(MAP_HEIGHT)));
        idx = 26'(r_grid[0][7:0]) + 26'(r_grid[1][7:0] * W9) +
              26'(r_grid[2][7:0] * WD17);
    end

    // Voxel store.
    logic                ram_we, ram_rdata;
    logic [STORE_AW-1:0] ram_waddr;
    logic                ram_wdata;

    assign ram_we    = i_cmd.clr_wr || i_cmd.wr_voxel;
    assign ram_waddr = i_cmd.clr_wr ? i_cmd.clr_addr : i_voxel_index;
    assign ram_wdata = i_cmd.clr_wr ? 1'b0 : (i_voxel_byte != 8'd0);

    vgrm_ram #(.WIDTH(1), .DEPTH(STORE_CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (idx[STORE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    logic [1:0] cell_val;
    assign cell_val = r_outside ? CELL_OUTSIDE : (r_past ? CELL_EMPTY : {1'b0, ram_rdata});
    assign o_status.cell_stop = (cell_val != CELL_EMPTY);

    // Working registers of the ray.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos[0]  <= i_start_x;
            r_pos[1]  <= i_start_y;
            r_pos[2]  <= i_start_z;
            r_dir[0]  <= i_dir_x;
            r_dir[1]  <= i_dir_y;
            r_dir[2]  <= i_dir_z;
            r_grid[0] <= start_cell(i_start_x);
            r_grid[1] <= start_cell(i_start_y);
            r_grid[2] <= start_cell(i_start_z);
            r_axis    <= AXIS_NONE;
            r_code    <= CELL_EMPTY;
        end
        if (i_cmd.div_start) begin
            r_nneg  <= num[18];
            r_dzero <= (den == '0);
        end
        if (i_cmd.div_cap) begin
            r_dist[i_cmd.axis] <= dist_val;
        end
        if (i_cmd.pick) begin
            r_d          <= r_dist[pick];
            r_grid[pick] <= (r_dir[pick] > 0) ? r_grid[pick] + GRID_W'(1)
                                              : r_grid[pick] - GRID_W'(1);
            r_axis       <= pick + 2'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= r_d * r_dir[i_cmd.axis];
        end
        if (i_cmd.acc) begin
            if (sum > 35'(POS_MAX)) begin
                r_pos[i_cmd.axis] <= POS_MAX;
            end else if (sum < 35'(POS_MIN)) begin
                r_pos[i_cmd.axis] <= POS_MIN;
            end else begin
                r_pos[i_cmd.axis] <= POS_W'(sum);
            end
        end
        if (i_cmd.rd) begin
            r_outside <= outside;
            r_past    <= (idx >= 26'(STORE_CELLS));
        end
        if (i_cmd.check) begin
            r_code <= cell_val;
        end
    end

    // Result register, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_hit_x    <= r_pos[0];
            r_hit_y    <= r_pos[1];
            r_hit_z    <= r_pos[2];
            r_out_axis <= r_axis;
            r_out_code <= r_code;
            r_out_neg  <= (r_axis != AXIS_NONE) && (r_dir[r_axis - 2'd1] > 0);
        end
    end

    assign o_hit_x           = r_hit_x;
    assign o_hit_y           = r_hit_y;
    assign o_hit_z           = r_hit_z;
    assign o_normal_axis     = r_out_axis;
    assign o_normal_negative = r_out_neg;
    assign o_cell_code       = r_out_code;

endmodule

FILE: sv/vgrm_ctrl.sv
module vgrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    output logic              o_valid,
    input  logic              i_ready,
    output vgrm_pkg::t_cmd    o_cmd,
    input  vgrm_pkg::t_status i_status
);
    import vgrm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_PICK,
        S_MUL, S_ACC, S_RD, S_CHECK, S_FIN
    } t_state;

    t_state              r_state;
    logic [STORE_AW-1:0] r_clr;
    logic [1:0]          r_k;
    logic [3:0]          r_step;
    logic [3:0]          r_max;
    logic                r_valid;
    logic                accept, last_step;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign last_step = (5'(r_step) + 5'd1) >= 5'(r_max);

    // Commands decoded from the state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.clr_addr  = r_clr;
        o_cmd.axis      = r_k;
        o_cmd.clr_wr    = (r_state == S_CLEAR);
        o_cmd.wr_voxel  = accept && (i_opcode == OP_WRITE);
        o_cmd.load      = accept && (i_opcode == OP_CAST);
        o_cmd.div_start = (r_state == S_DIV_GO);
        o_cmd.div_cap   = (r_state == S_DIV_WAIT) && i_status.div_done;
        o_cmd.pick      = (r_state == S_PICK);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.rd        = (r_state == S_RD);
        o_cmd.check     = (r_state == S_CHECK);
        o_cmd.publish   = (r_state == S_FIN) && (!r_valid || i_ready);
    end

    // Sequencer: per step three divisions, a pick, three updates and a cell read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_k     <= '0;
            r_step  <= '0;
            r_max   <= MAX_STEPS_RST;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (o_cmd.publish) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {STORE_AW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_step  <= '0;
                        r_k     <= '0;
                        r_state <= (r_max == 4'd0) ? S_FIN : S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_status.div_done) begin
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_PICK;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_PICK: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_RD: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_step <= r_step + 4'd1;
                    if (i_status.cell_stop || last_step) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_FIN: begin
                    if (o_cmd.publish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: sv/voxel_grid_ray_march.sv
// Voxel ray marcher with a 32x32x8 (parameterized) solid/empty map.
// Input channel (i_valid/o_ready) carries one item: opcode 0 writes the
// voxel at i_voxel_index (nonzero byte means solid), opcode 1 casts a ray
// from i_start_* along i_dir_*. A write yields no result; a cast yields one
// result item on the output channel (o_valid/i_ready): hit point, face
// normal and the code of the last cell visited.
// A cast runs, per boundary crossing, three divisions on the shared
// bit-serial divider, the pick, the three position updates and the map
// read; it stops at a non-empty cell or after max_steps crossings.
// The divider makes one quotient bit per cycle.
// After reset all 8192 map cells are cleared, one cell per cycle;
// o_ready stays low meanwhile. max_steps resets to 4.
// The result sits in an output register: while the receiver stalls, writes
// go on being taken, and the next cast runs and then waits for the register.
// i_cfg_we writes max_steps; write it only while the block is idle.
module voxel_grid_ray_march #(
    parameter int MAP_WIDTH  = vgrm_pkg::MAP_WIDTH_DEF,
    parameter int MAP_DEPTH  = vgrm_pkg::MAP_DEPTH_DEF,
    parameter int MAP_HEIGHT = vgrm_pkg::MAP_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [3:0]                        i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [12:0]                       i_voxel_index,
    input  logic [7:0]                        i_voxel_byte,
    input  logic signed [vgrm_pkg::POS_W-1:0] i_start_x,
    input  logic signed [vgrm_pkg::POS_W-1:0] i_start_y,
    input  logic signed [vgrm_pkg::POS_W-1:0] i_start_z,
    input  logic signed [vgrm_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [vgrm_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [vgrm_pkg::DIR_W-1:0] i_dir_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [vgrm_pkg::POS_W-1:0] o_hit_x,
    output logic signed [vgrm_pkg::POS_W-1:0] o_hit_y,
    output logic signed [vgrm_pkg::POS_W-1:0] o_hit_z,
    output logic [1:0]                        o_normal_axis,
    output logic                              o_normal_negative,
    output logic [1:0]                        o_cell_code
);
    import vgrm_pkg::*;

    t_cmd    cmd;
    t_status status;

    vgrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    vgrm_datapath #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_DEPTH  (MAP_DEPTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_voxel_index     (i_voxel_index),
        .i_voxel_byte      (i_voxel_byte),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_start_z         (i_start_z),
        .i_dir_x           (i_dir_x),
        .i_dir_y           (i_dir_y),
        .i_dir_z           (i_dir_z),
        .o_hit_x           (o_hit_x),
        .o_hit_y           (o_hit_y),
        .o_hit_z           (o_hit_z),
        .o_normal_axis     (o_normal_axis),
        .o_normal_negative (o_normal_negative),
        .o_cell_code       (o_cell_code)
    );

    // A division is never started while one is still running.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    // A new result never overwrites one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_valid || i_ready))
        else $error("result overwritten");

    // No item is taken while the map is being cleared.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !o_ready)
        else $error("item accepted during clear");

    // A publish is followed by a valid result.
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_valid)
        else $error("published result not shown");

endmodule
